// ===== sv/dqse_pkg.sv =====
// ----------------------------------------------------------------------------
// dqse_pkg
// Shared types and codes for the dual quadrature speed estimator.
// ----------------------------------------------------------------------------
package dqse_pkg;

  localparam int DATA_W  = 16;
  localparam int TOTAL_W = 32;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_SPEED = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_INVERT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_INVERT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS        = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic       wheel;
    logic       phase;
    logic       other_level;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  left_delta;
    logic signed [DATA_W-1:0]  right_delta;
    logic signed [TOTAL_W-1:0] left_total;
    logic signed [TOTAL_W-1:0] right_total;
    logic signed [DATA_W-1:0]  left_speed;
    logic signed [DATA_W-1:0]  right_speed;
    logic                      speed_updated;
  } out_item_t;

endpackage

// ===== sv/dqse_core.sv =====
// ----------------------------------------------------------------------------
// dqse_core
// Encoder state, window latching, tick counter and filter history; one word
// per cycle on accept, results registered into the first pipeline stage.
// ----------------------------------------------------------------------------
module dqse_core #(
  parameter int FILTER_TAPS = 5,
  parameter int SUM_W       = 16 + $clog2(FILTER_TAPS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dqse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dqse_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              accept,
  input  dqse_pkg::in_item_t                item,
  output dqse_pkg::out_item_t               s1_data,
  output logic signed [SUM_W-1:0]           s1_sum [2]
);
  import dqse_pkg::*;

  logic                      invert [2];
  logic [7:0]                ticks_per_speed;

  logic [DATA_W-1:0]         raw_count [2];
  logic [DATA_W-1:0]         window_delta [2];
  logic [TOTAL_W-1:0]        pulse_total [2];
  logic [DATA_W-1:0]         speed_acc [2];
  logic [7:0]                tick_counter;
  logic                      speed_ready;
  logic signed [DATA_W-1:0]  hist [2][FILTER_TAPS];
  logic signed [SUM_W-1:0]   hist_sum [2];

  logic [DATA_W-1:0]         raw_count_next [2];
  logic [DATA_W-1:0]         window_delta_next [2];
  logic [TOTAL_W-1:0]        pulse_total_next [2];
  logic [DATA_W-1:0]         speed_acc_next [2];
  logic [7:0]                tick_counter_next;
  logic                      speed_ready_next;
  logic signed [SUM_W-1:0]   hist_sum_next [2];
  logic                      push;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      invert[0]       <= 1'b0;
      invert[1]       <= 1'b1;
      ticks_per_speed <= 8'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LEFT_INVERT:  invert[0]       <= cfg_data[0];
        CFG_RIGHT_INVERT: invert[1]       <= cfg_data[0];
        CFG_TICKS:        ticks_per_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic              up;
    logic [DATA_W-1:0] d;
    logic [7:0]        tick_inc;
    for (int k = 0; k < 2; k++) begin
      raw_count_next[k]    = raw_count[k];
      window_delta_next[k] = window_delta[k];
      pulse_total_next[k]  = pulse_total[k];
      speed_acc_next[k]    = speed_acc[k];
      hist_sum_next[k]     = hist_sum[k];
    end
    tick_counter_next = tick_counter;
    speed_ready_next  = speed_ready;
    push              = 1'b0;
    up                = item.phase ? !item.other_level : item.other_level;
    d                 = '0;
    tick_inc          = tick_counter + 8'd1;

    case (item.command)
      CMD_EDGE: begin
        raw_count_next[item.wheel] = raw_count[item.wheel] + (up ? 16'h0001 : 16'hFFFF);
      end
      CMD_TICK: begin
        for (int k = 0; k < 2; k++) begin
          d = invert[k] ? DATA_W'(-raw_count[k]) : raw_count[k];
          window_delta_next[k] = d;
          pulse_total_next[k]  = pulse_total[k] + {{(TOTAL_W-DATA_W){d[DATA_W-1]}}, d};
          speed_acc_next[k]    = speed_acc[k] + d;
          raw_count_next[k]    = '0;
        end
        if (tick_inc >= ticks_per_speed) begin
          tick_counter_next = '0;
          speed_ready_next  = 1'b1;
        end else begin
          tick_counter_next = tick_inc;
        end
      end
      CMD_SPEED: begin
        if (speed_ready) begin
          speed_ready_next = 1'b0;
          push             = 1'b1;
          // running sum: add newest sample, drop the oldest one as it shifts out of the history
          for (int k = 0; k < 2; k++) begin
            hist_sum_next[k]  = hist_sum[k] + SUM_W'(signed'(speed_acc[k]))
                                - SUM_W'(hist[k][FILTER_TAPS-1]);
            speed_acc_next[k] = '0;
          end
        end
      end
      CMD_READ: begin
        window_delta_next[item.wheel] = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 2; k++) begin
        raw_count[k]    <= '0;
        window_delta[k] <= '0;
        pulse_total[k]  <= '0;
        speed_acc[k]    <= '0;
        hist_sum[k]     <= '0;
        for (int i = 0; i < FILTER_TAPS; i++) begin
          hist[k][i] <= '0;
        end
      end
      tick_counter <= '0;
      speed_ready  <= 1'b0;
    end else if (accept) begin
      for (int k = 0; k < 2; k++) begin
        raw_count[k]    <= raw_count_next[k];
        window_delta[k] <= window_delta_next[k];
        pulse_total[k]  <= pulse_total_next[k];
        speed_acc[k]    <= speed_acc_next[k];
        hist_sum[k]     <= hist_sum_next[k];
        if (push) begin
          hist[k][0] <= signed'(speed_acc[k]);
          for (int i = 1; i < FILTER_TAPS; i++) begin
            hist[k][i] <= hist[k][i-1];
          end
        end
      end
      tick_counter <= tick_counter_next;
      speed_ready  <= speed_ready_next;
    end
  end

  // stage 1 payload; speeds are filled in at the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data.left_delta    <= signed'((item.command == CMD_READ) ? window_delta[0]
                                                                   : window_delta_next[0]);
      s1_data.right_delta   <= signed'((item.command == CMD_READ) ? window_delta[1]
                                                                   : window_delta_next[1]);
      s1_data.left_total    <= signed'(pulse_total_next[0]);
      s1_data.right_total   <= signed'(pulse_total_next[1]);
      s1_data.left_speed    <= '0;
      s1_data.right_speed   <= '0;
      s1_data.speed_updated <= push;
      s1_sum[0]             <= hist_sum_next[0];
      s1_sum[1]             <= hist_sum_next[1];
    end
  end

endmodule

// ===== sv/dqse_avg_div.sv =====
// ----------------------------------------------------------------------------
// dqse_avg_div
// Signed divide of the history sum by the tap count, truncating toward zero.
// Reciprocal multiply into a register, then a one-step remainder correction.
// ----------------------------------------------------------------------------
module dqse_avg_div #(
  parameter int TAPS  = 5,
  parameter int SUM_W = 16 + $clog2(TAPS)
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic signed [SUM_W-1:0] sum,
  output logic signed [15:0]      avg
);
  import dqse_pkg::*;

  localparam int          SH      = SUM_W;
  localparam int unsigned RECIP_I = (32'd1 << SH) / TAPS;
  localparam logic [SH:0] RECIP   = (SH+1)'(RECIP_I);
  localparam int          PROD_W  = SUM_W + SH + 1;
  localparam logic [SUM_W-1:0] TAPS_V = SUM_W'(TAPS);

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  q0;
  logic [SUM_W-1:0]  q0_r;
  logic [SUM_W-1:0]  mag_r;
  logic              neg_r;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  q;
  logic [SUM_W-1:0]  res;

  // magnitude of the most negative sum wraps onto the right unsigned value
  assign neg  = sum[SUM_W-1];
  assign mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);
  assign q0   = prod[SH +: SUM_W];

  always_ff @(posedge clk) begin
    if (load) begin
      q0_r  <= q0;
      mag_r <= mag;
      neg_r <= neg;
    end
  end

  // estimate is low by at most one
  assign rem = mag_r - q0_r * TAPS_V;
  assign q   = q0_r + SUM_W'(rem >= TAPS_V);
  assign res = neg_r ? SUM_W'(-q) : q;
  assign avg = signed'(res[15:0]);

endmodule

// ===== sv/dual_quadrature_speed_estimator.sv =====
// ----------------------------------------------------------------------------
// dual_quadrature_speed_estimator
// Two-wheel quadrature counter with window deltas, totals and moving-average
// speed.
// ----------------------------------------------------------------------------
// Takes one command word per clock while item_ready is high (edge, window
// tick, speed update, read) and returns one result word per command, in
// order; a stalled receiver holds the flow. From acceptance to a valid
// result, the state update registers into stage 1, the reciprocal multiply
// of the filter sum registers into stage 2, and the remainder correction
// feeds the result register. The filter sum is kept as a running total, so
// no tap adder tree sits in the path. Config writes (cfg_write, cfg_index,
// cfg_data) take effect at once and are meant only while the pipeline is
// drained; an index past the last register is ignored.
// ----------------------------------------------------------------------------
module dual_quadrature_speed_estimator #(
  parameter int FILTER_TAPS = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dqse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dqse_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  dqse_pkg::in_item_t             item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output dqse_pkg::out_item_t            result
);
  import dqse_pkg::*;

  localparam int SUM_W = 16 + $clog2(FILTER_TAPS);

  logic                     accept;
  logic                     s1_valid;
  logic                     s2_valid;
  logic                     out_free;
  logic                     s2_ready;
  logic                     s1_ready;
  logic                     s2_load;
  logic                     out_load;

  out_item_t                s1_data;
  out_item_t                s2_data;
  logic signed [SUM_W-1:0]  s1_sum [2];
  logic signed [15:0]       avg [2];
  logic signed [15:0]       filtered_speed [2];

  // elastic pipeline: each stage fills when it is empty or the next one is free
  assign out_free   = !result_valid || result_ready;
  assign s2_ready   = !s2_valid || out_free;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_ready = s1_ready;
  assign accept     = item_valid && item_ready;
  assign s2_load    = s1_valid && s2_ready;
  assign out_load   = s2_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (out_load) begin
        s2_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  dqse_core #(
    .FILTER_TAPS (FILTER_TAPS),
    .SUM_W       (SUM_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .s1_data   (s1_data),
    .s1_sum    (s1_sum)
  );

  // one divider per wheel; stage 2 register lives inside
  for (genvar k = 0; k < 2; k++) begin : g_div
    dqse_avg_div #(
      .TAPS  (FILTER_TAPS),
      .SUM_W (SUM_W)
    ) u_div (
      .clk  (clk),
      .load (s2_load),
      .sum  (s1_sum[k]),
      .avg  (avg[k])
    );
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_data <= s1_data;
    end
  end

  // filtered speed only changes here, so words behind an update see it in order
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_speed[0] <= '0;
      filtered_speed[1] <= '0;
    end else if (out_load && s2_data.speed_updated) begin
      filtered_speed[0] <= avg[0];
      filtered_speed[1] <= avg[1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.left_delta    <= s2_data.left_delta;
      result.right_delta   <= s2_data.right_delta;
      result.left_total    <= s2_data.left_total;
      result.right_total   <= s2_data.right_total;
      result.left_speed    <= s2_data.speed_updated ? avg[0] : filtered_speed[0];
      result.right_speed   <= s2_data.speed_updated ? avg[1] : filtered_speed[1];
      result.speed_updated <= s2_data.speed_updated;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual quadrature speed estimator.
// ----------------------------------------------------------------------------
// A short directed table walks the reset state, every edge decode, ticks,
// speed updates with and without the ready flag, and reads. Random phases
// follow. Each phase runs under its own invert and tick settings and its own
// mix of sender gaps and receiver stalls. Every accepted command word is run
// through a local model of the estimator. Each result word is checked field
// by field against the oldest predicted readout.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dqse_pkg::*;

  localparam int TAPS       = 5;
  localparam int TIMEOUT_NS = 3_000_000;

  // one row of the directed table; want is used only when literal is set
  typedef struct {
    in_item_t  word;
    bit        literal;
    out_item_t want;
  } plan_row_t;

  // one random phase: register settings, idling mix, length
  typedef struct {
    bit         left_inv;
    bit         right_inv;
    logic [7:0] ticks;
    int         send_idle;
    int         recv_stall;
    int         words;
    bit         tick_heavy;
  } phase_t;

  localparam out_item_t NO_CHANGE  = '0;
  localparam out_item_t FIRST_TICK = '{left_delta: 16'sd1, right_delta: -16'sd2,
                                       left_total: 32'sd1, right_total: -32'sd2,
                                       left_speed: '0, right_speed: '0,
                                       speed_updated: 1'b0};

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 item_valid;
  logic                 item_ready;
  in_item_t             item;
  logic                 result_valid;
  logic                 result_ready;
  out_item_t            result;

  // local copy of the estimator state and its registers
  logic        m_left_inv;
  logic        m_right_inv;
  logic [7:0]  m_ticks;
  logic [15:0] raw_cnt [2];
  logic [15:0] win_delta [2];
  logic [31:0] pulse_sum [2];
  logic [15:0] speed_acc [2];
  logic [7:0]  tick_cnt;
  logic        speed_rdy;
  logic [15:0] hist [2][TAPS];
  int          hist_pos [2];
  logic [15:0] filt_speed [2];

  out_item_t readouts_due [$];
  int        fails;
  int        words_sent;
  int        speed_updates;
  int        settings_run;
  int        send_idle_pct;
  int        recv_stall_pct;

  dual_quadrature_speed_estimator #(
    .FILTER_TAPS(TAPS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("testbench failed");
    $finish;
  end

  // Advance the local model by one command word and return the readout the
  // block should give for it.
  function automatic out_item_t next_readout(in_item_t w);
    out_item_t   r;
    logic [15:0] d;
    logic        up;
    logic        inv;
    int          sum;
    int          p;
    logic        updated;
    updated = 1'b0;
    case (cmd_t'(w.command))
      CMD_EDGE: begin
        // A rising counts up with B high, B rising counts up with A low
        up = (w.phase == 1'b0) ? w.other_level : !w.other_level;
        raw_cnt[w.wheel] = raw_cnt[w.wheel] + (up ? 16'h0001 : 16'hFFFF);
      end
      CMD_TICK: begin
        for (int k = 0; k < 2; k++) begin
          inv = (k == 0) ? m_left_inv : m_right_inv;
          d = inv ? 16'd0 - raw_cnt[k] : raw_cnt[k];
          win_delta[k] = d;
          pulse_sum[k] = pulse_sum[k] + {{16{d[15]}}, d};
          speed_acc[k] = speed_acc[k] + d;
          raw_cnt[k] = '0;
        end
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= m_ticks) begin
          tick_cnt = '0;
          speed_rdy = 1'b1;
        end
      end
      CMD_SPEED: begin
        // without the ready flag a speed command changes nothing
        if (speed_rdy) begin
          speed_rdy = 1'b0;
          for (int k = 0; k < 2; k++) begin
            p = (hist_pos[k] >= TAPS) ? 0 : hist_pos[k];
            hist[k][p] = speed_acc[k];
            hist_pos[k] = (p + 1 >= TAPS) ? 0 : p + 1;
            sum = 0;
            for (int i = 0; i < TAPS; i++) sum = sum + $signed(hist[k][i]);
            // integer division truncates toward zero
            filt_speed[k] = 16'(sum / TAPS);
            speed_acc[k] = '0;
          end
          updated = 1'b1;
        end
      end
      default: ;
    endcase
    r.left_delta    = win_delta[0];
    r.right_delta   = win_delta[1];
    r.left_total    = pulse_sum[0];
    r.right_total   = pulse_sum[1];
    r.left_speed    = filt_speed[0];
    r.right_speed   = filt_speed[1];
    r.speed_updated = updated;
    // a read shows the delta, then clears it
    if (cmd_t'(w.command) == CMD_READ) win_delta[w.wheel] = '0;
    return r;
  endfunction

  function automatic plan_row_t row(cmd_t c, logic wh, logic ph, logic lv, bit lit,
                                    out_item_t want);
    plan_row_t r;
    r.word.command     = c;
    r.word.wheel       = wh;
    r.word.phase       = ph;
    r.word.other_level = lv;
    r.literal          = lit;
    r.want             = want;
    return r;
  endfunction

  // Present one command word, with random gaps ahead of it, and hold it until
  // the block takes it. Starts and ends at a falling edge.
  task automatic send_word(in_item_t w, bit literal, out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    // the model advances on every accepted word, typed-in rows included
    predicted = next_readout(w);
    readouts_due.push_back(literal ? want : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // receiver: random stalls, re-rolled every cycle
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker: compare each accepted word with the oldest prediction
  out_item_t want_now;
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (readouts_due.size() == 0) begin
        $error("result word with no prediction waiting");
        fails++;
      end else begin
        want_now = readouts_due.pop_front();
        if (result.left_delta !== want_now.left_delta) begin
          $error("left_delta: expected %0d, got %0d", want_now.left_delta,
                 result.left_delta);
          fails++;
        end
        if (result.right_delta !== want_now.right_delta) begin
          $error("right_delta: expected %0d, got %0d", want_now.right_delta,
                 result.right_delta);
          fails++;
        end
        if (result.left_total !== want_now.left_total) begin
          $error("left_total: expected %0d, got %0d", want_now.left_total,
                 result.left_total);
          fails++;
        end
        if (result.right_total !== want_now.right_total) begin
          $error("right_total: expected %0d, got %0d", want_now.right_total,
                 result.right_total);
          fails++;
        end
        if (result.left_speed !== want_now.left_speed) begin
          $error("left_speed: expected %0d, got %0d", want_now.left_speed,
                 result.left_speed);
          fails++;
        end
        if (result.right_speed !== want_now.right_speed) begin
          $error("right_speed: expected %0d, got %0d", want_now.right_speed,
                 result.right_speed);
          fails++;
        end
        if (result.speed_updated !== want_now.speed_updated) begin
          $error("speed_updated: expected %0d, got %0d", want_now.speed_updated,
                 result.speed_updated);
          fails++;
        end
        if (result.speed_updated === 1'b1) speed_updates++;
      end
    end
  end

  plan_row_t plan [$];
  phase_t    phases [8];
  in_item_t  w;
  logic      up;
  int        len;
  int        pick;
  int        phase_start;

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    item_valid     = 1'b0;
    item           = '0;
    fails          = 0;
    words_sent     = 0;
    speed_updates  = 0;
    settings_run   = 1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // model state and register values after reset
    m_left_inv  = 1'b0;
    m_right_inv = 1'b1;
    m_ticks     = 8'd2;
    tick_cnt    = '0;
    speed_rdy   = 1'b0;
    for (int k = 0; k < 2; k++) begin
      raw_cnt[k]    = '0;
      win_delta[k]  = '0;
      pulse_sum[k]  = '0;
      speed_acc[k]  = '0;
      filt_speed[k] = '0;
      hist_pos[k]   = 0;
      for (int i = 0; i < TAPS; i++) hist[k][i] = '0;
    end

    // settings per phase: defaults, both invert extremes, ticks 1 and 255
    phases = '{
      '{1'b0, 1'b1, 8'd2,   0,  0,  200, 1'b0},
      '{1'b1, 1'b0, 8'd1,   83, 0,  200, 1'b0},
      '{1'b0, 1'b0, 8'd3,   0,  83, 200, 1'b0},
      '{1'b1, 1'b1, 8'd255, 32, 32, 400, 1'b1},
      '{1'b0, 1'b1, 8'd1,   0,  0,  200, 1'b0},
      '{1'b1, 1'b0, 8'd16,  83, 0,  200, 1'b0},
      '{1'b0, 1'b0, 8'd7,   0,  83, 200, 1'b0},
      '{1'b1, 1'b1, 8'd2,   32, 32, 250, 1'b0}
    };

    // directed table, run under the reset settings
    // speed without ready and a read straight out of reset: all zero
    plan.push_back(row(CMD_SPEED, 1'b0, 1'b0, 1'b0, 1'b1, NO_CHANGE));
    plan.push_back(row(CMD_READ,  1'b1, 1'b1, 1'b1, 1'b1, NO_CHANGE));
    // every edge decode on the left wheel, both phases at both levels; edges never move the outputs
    plan.push_back(row(CMD_EDGE,  1'b0, 1'b0, 1'b1, 1'b1, NO_CHANGE));
    plan.push_back(row(CMD_EDGE,  1'b0, 1'b0, 1'b0, 1'b1, NO_CHANGE));
    plan.push_back(row(CMD_EDGE,  1'b0, 1'b1, 1'b1, 1'b1, NO_CHANGE));
    plan.push_back(row(CMD_EDGE,  1'b0, 1'b1, 1'b0, 1'b1, NO_CHANGE));
    plan.push_back(row(CMD_EDGE,  1'b0, 1'b0, 1'b1, 1'b1, NO_CHANGE));
    plan.push_back(row(CMD_EDGE,  1'b1, 1'b0, 1'b1, 1'b1, NO_CHANGE));
    plan.push_back(row(CMD_EDGE,  1'b1, 1'b1, 1'b0, 1'b1, NO_CHANGE));
    // left +1 as is, right +2 negated by the reset invert
    plan.push_back(row(CMD_TICK,  1'b1, 1'b1, 1'b1, 1'b1, FIRST_TICK));
    plan.push_back(row(CMD_SPEED, 1'b1, 1'b0, 1'b1, 1'b0, NO_CHANGE));
    plan.push_back(row(CMD_EDGE,  1'b1, 1'b1, 1'b1, 1'b0, NO_CHANGE));
    // second tick sets the ready flag
    plan.push_back(row(CMD_TICK,  1'b0, 1'b0, 1'b0, 1'b0, NO_CHANGE));
    plan.push_back(row(CMD_READ,  1'b0, 1'b1, 1'b0, 1'b0, NO_CHANGE));
    plan.push_back(row(CMD_TICK,  1'b0, 1'b1, 1'b0, 1'b0, NO_CHANGE));
    plan.push_back(row(CMD_SPEED, 1'b0, 1'b1, 1'b1, 1'b0, NO_CHANGE));
    plan.push_back(row(CMD_SPEED, 1'b1, 1'b1, 1'b0, 1'b0, NO_CHANGE));
    plan.push_back(row(CMD_READ,  1'b1, 1'b0, 1'b1, 1'b0, NO_CHANGE));
    plan.push_back(row(CMD_EDGE,  1'b0, 1'b1, 1'b0, 1'b0, NO_CHANGE));
    plan.push_back(row(CMD_EDGE,  1'b0, 1'b1, 1'b0, 1'b0, NO_CHANGE));
    plan.push_back(row(CMD_TICK,  1'b1, 1'b0, 1'b0, 1'b0, NO_CHANGE));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) send_word(plan[i].word, plan[i].literal, plan[i].want);

    foreach (phases[ph]) begin
      // drain before touching registers
      item_valid <= 1'b0;
      while (readouts_due.size() != 0) @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= CFG_LEFT_INVERT;
      cfg_data  <= {7'd0, phases[ph].left_inv};
      @(negedge clk);
      cfg_index <= CFG_RIGHT_INVERT;
      cfg_data  <= {7'd0, phases[ph].right_inv};
      @(negedge clk);
      cfg_index <= CFG_TICKS;
      cfg_data  <= phases[ph].ticks;
      @(negedge clk);
      cfg_write <= 1'b0;
      m_left_inv     = phases[ph].left_inv;
      m_right_inv    = phases[ph].right_inv;
      m_ticks        = phases[ph].ticks;
      send_idle_pct  = phases[ph].send_idle;
      recv_stall_pct = phases[ph].recv_stall;
      settings_run++;

      phase_start = words_sent;
      while (words_sent - phase_start < phases[ph].words) begin
        pick = $urandom_range(99);
        // the tick-heavy phase runs past 255 ticks so the widest window closes
        if (phases[ph].tick_heavy) pick = (pick < 75) ? 55 : pick;
        w = in_item_t'(5'($urandom));
        if (pick < 50) begin
          // a run of consistent quadrature edges on one wheel
          up  = 1'($urandom);
          len = $urandom_range(24, 1);
          for (int n = 0; n < len; n++) begin
            w.command     = CMD_EDGE;
            w.phase       = 1'($urandom);
            w.other_level = (w.phase == 1'b0) ? up : !up;
            send_word(w, 1'b0, NO_CHANGE);
          end
        end else if (pick < 66) begin
          w.command = CMD_TICK;
          send_word(w, 1'b0, NO_CHANGE);
        end else if (pick < 80) begin
          w.command = CMD_SPEED;
          send_word(w, 1'b0, NO_CHANGE);
        end else if (pick < 90) begin
          w.command = CMD_READ;
          send_word(w, 1'b0, NO_CHANGE);
        end else begin
          // noise: anything at all, edges in either direction
          send_word(w, 1'b0, NO_CHANGE);
        end
      end
    end

    item_valid <= 1'b0;
    for (int n = 0; n < 5000 && readouts_due.size() != 0; n++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (readouts_due.size() != 0) begin
      $error("%0d predicted result words never arrived", readouts_due.size());
      fails++;
    end

    $display("Summary: %0d command words over %0d register settings, %0d speed updates",
             words_sent, settings_run, speed_updates);
    $display("Summary: %0d mismatches or missing words", fails);
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dqse_pkg.sv
sv/dqse_core.sv
sv/dqse_avg_div.sv
sv/dual_quadrature_speed_estimator.sv
tb/sv/testbench.sv
